### design/lz_token_decompressor_unit_macros.svh
// Assertion macros for the LZ token decompressor.
// Used by the top level; no other dependencies.
`ifndef LZ_TOKEN_DECOMPRESSOR_UNIT_MACROS_SVH
`define LZ_TOKEN_DECOMPRESSOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LZTD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LZTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lztd_pkg.sv
// Shared types and constants for the LZ token decompressor.
// No dependencies; compiled first.
package lztd_pkg;

  localparam int WINDOW_DEPTH_DEF = 65536;
  localparam int OUT_LANES_DEF    = 8;

  localparam int DATA_W     = 64;
  localparam int CNT_W      = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int LEN_W      = 9;

  localparam logic [1:0] DIST_EXT     = 2'b11;
  localparam logic [7:0] MLEN_BIAS    = 8'd2;
  localparam logic       REG_OUT_SIZE = 1'b0;

  typedef enum logic [2:0] {
    PH_TOKEN,
    PH_LITEXT,
    PH_MATEXT,
    PH_LIT,
    PH_DLOW,
    PH_DHIGH,
    PH_SETUP,
    PH_COPY
  } phase_t;

  typedef struct packed {
    logic tok_load;
    logic litext_load;
    logic matext_load;
    logic lit_emit;
    logic dlow_load;
    logic dhigh_load;
    logic setup;
    logic copy_en;
  } cmd_t;

  typedef struct packed {
    logic b_lit_zero;
    logic b_lit_one;
    logic b_mat_zero;
    logic b_le1;
    logic b_zero;
    logic tok_mat_zero;
    logic tok_dist_ext;
    logic lit_zero;
    logic lit_one;
    logic match_zero;
    logic limit;
    logic out_free;
    logic copy_done;
  } sts_t;

endpackage

### design/lztd_in_if.sv
// Compressed-byte channel: valid/ready plus one stream byte.
// Depends on nothing.
interface lztd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

### design/lztd_out_if.sv
// Result channel: valid/ready plus packed output bytes and flags.
// Depends on lztd_pkg.
interface lztd_out_if;
  import lztd_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] out_data;
  logic [CNT_W-1:0]  out_count;
  logic              run_last;
  logic              bad_distance;
  logic              limit_reached;

  modport source (output valid, output out_data, output out_count, output run_last,
                  output bad_distance, output limit_reached, input ready);
  modport sink   (input valid, input out_data, input out_count, input run_last,
                  input bad_distance, input limit_reached, output ready);
endinterface

### design/lztd_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// Read-first on an address collision. No dependencies.
module lztd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/lztd_ctrl.sv
// Parser and copy sequencer state machine.
// Depends on lztd_pkg; drives commands to lztd_dp and reads its status.
module lztd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lztd_pkg::sts_t sts,
  output lztd_pkg::cmd_t cmd
);
  import lztd_pkg::*;

  phase_t state, state_next;
  logic   fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_TOKEN;
    end else begin
      state <= state_next;
    end
  end

  assign fire = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      PH_TOKEN: begin
        in_ready = 1'b1;
        // past the size limit, stream bytes are swallowed here
        if (fire && !sts.limit) begin
          cmd.tok_load = 1'b1;
          if (sts.b_lit_zero) begin
            state_next = PH_LITEXT;
          end else if (sts.b_mat_zero) begin
            state_next = PH_MATEXT;
          end else if (!sts.b_lit_one) begin
            state_next = PH_LIT;
          end else begin
            state_next = PH_DLOW;
          end
        end
      end
      PH_LITEXT: begin
        in_ready = 1'b1;
        if (fire) begin
          cmd.litext_load = 1'b1;
          if (sts.tok_mat_zero) begin
            state_next = PH_MATEXT;
          end else if (!sts.b_le1) begin
            state_next = PH_LIT;
          end else begin
            state_next = PH_DLOW;
          end
        end
      end
      PH_MATEXT: begin
        in_ready = 1'b1;
        if (fire) begin
          cmd.matext_load = 1'b1;
          if (!sts.lit_zero) begin
            state_next = PH_LIT;
          end else if (!sts.b_zero) begin
            state_next = PH_DLOW;
          end else begin
            state_next = PH_TOKEN;
          end
        end
      end
      PH_LIT: begin
        in_ready = sts.out_free;
        if (fire) begin
          cmd.lit_emit = 1'b1;
          if (sts.lit_one) begin
            state_next = sts.match_zero ? PH_TOKEN : PH_DLOW;
          end
        end
      end
      PH_DLOW: begin
        in_ready = 1'b1;
        if (fire) begin
          cmd.dlow_load = 1'b1;
          state_next    = sts.tok_dist_ext ? PH_DHIGH : PH_SETUP;
        end
      end
      PH_DHIGH: begin
        in_ready = 1'b1;
        if (fire) begin
          cmd.dhigh_load = 1'b1;
          state_next     = PH_SETUP;
        end
      end
      PH_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = PH_COPY;
      end
      PH_COPY: begin
        cmd.copy_en = 1'b1;
        if (sts.copy_done) begin
          state_next = PH_TOKEN;
        end
      end
      default: begin
        state_next = PH_TOKEN;
      end
    endcase
  end

endmodule

### design/lztd_dp.sv
// Datapath: token fields, history window, copy engine, lane packer and
// output register. Depends on lztd_pkg and lztd_ram.
module lztd_dp #(
  parameter int WINDOW_DEPTH = lztd_pkg::WINDOW_DEPTH_DEF,
  parameter int OUT_LANES    = lztd_pkg::OUT_LANES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lztd_pkg::cmd_t               cmd,
  output lztd_pkg::sts_t               sts,
  input  logic [7:0]                   in_byte,
  input  logic [31:0]                  out_size,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [lztd_pkg::DATA_W-1:0]  out_data,
  output logic [lztd_pkg::CNT_W-1:0]   out_count,
  output logic                         run_last,
  output logic                         bad_distance,
  output logic                         limit_reached
);
  import lztd_pkg::*;

  localparam int ADDR_W = $clog2(WINDOW_DEPTH);
  localparam int LANE_W = $clog2(OUT_LANES + 1);
  localparam int CW     = ADDR_W + 2;
  localparam logic [16:0] DEPTH_V = 17'(WINDOW_DEPTH);

  logic [7:0]        token, lit_left, match_len, dist_low, dist_high;
  logic [31:0]       bytes_out, bytes_out_inc;
  logic [ADDR_W-1:0] wpos, wpos_inc, rpos, rpos_inc, rpos_calc;
  logic [LEN_W-1:0]  cons_left;
  logic              bad, bad_calc, pend, fwd;
  logic [7:0]        fwd_byte, rd_data, copy_byte, wr_data;
  logic [DATA_W-1:0] pack_data, lane_bits;
  logic [LANE_W-1:0] pack_lane;
  logic              wr_en, issue, consume, completes, copy_last, out_free, limit_next;
  logic [15:0]       dist16;
  logic [CW-1:0]     dist_c, wpos_c;

  assign wpos_inc      = (wpos == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : wpos + 1'b1;
  assign rpos_inc      = (rpos == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : rpos + 1'b1;
  assign bytes_out_inc = (bytes_out == '1) ? bytes_out : bytes_out + 32'd1;
  assign limit_next    = bytes_out_inc >= out_size;
  assign out_free      = !out_valid || out_ready;

  // match setup: distance check and start of the read pointer
  assign dist16   = {dist_high, dist_low};
  assign bad_calc = (dist16 == 16'd0) || (32'(dist16) > bytes_out) || (17'(dist16) > DEPTH_V);
  assign dist_c   = CW'(dist16);
  assign wpos_c   = CW'(wpos);
  always_comb begin
    if (wpos_c >= dist_c) begin
      rpos_calc = ADDR_W'(wpos_c - dist_c);
    end else begin
      rpos_calc = ADDR_W'(wpos_c + CW'(WINDOW_DEPTH) - dist_c);
    end
  end

  // copy engine: one read in flight, next read issued as the current byte retires
  assign copy_last = cons_left == LEN_W'(1);
  assign completes = (pack_lane == LANE_W'(OUT_LANES - 1)) || copy_last;
  assign consume   = cmd.copy_en && pend && (!completes || out_free);
  assign issue     = cmd.copy_en && (pend ? (consume && !copy_last) : (cons_left != '0));
  assign copy_byte = bad ? 8'd0 : (fwd ? fwd_byte : rd_data);
  assign lane_bits = DATA_W'(copy_byte) << {pack_lane, 3'b000};

  assign wr_en   = cmd.lit_emit || consume;
  assign wr_data = cmd.lit_emit ? in_byte : copy_byte;

  lztd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_DEPTH)
  ) u_history (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wpos),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rpos),
    .rd_data (rd_data)
  );

  always_comb begin
    sts.b_lit_zero   = in_byte[1:0] == 2'd0;
    sts.b_lit_one    = in_byte[1:0] == 2'd1;
    sts.b_mat_zero   = in_byte[7:4] == 4'd0;
    sts.b_le1        = in_byte[7:1] == 7'd0;
    sts.b_zero       = in_byte == 8'd0;
    sts.tok_mat_zero = token[7:4] == 4'd0;
    sts.tok_dist_ext = token[3:2] == DIST_EXT;
    sts.lit_zero     = lit_left == 8'd0;
    sts.lit_one      = lit_left == 8'd1;
    sts.match_zero   = match_len == 8'd0;
    sts.limit        = bytes_out >= out_size;
    sts.out_free     = out_free;
    sts.copy_done    = cons_left == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token     <= '0;
      lit_left  <= '0;
      match_len <= '0;
      dist_low  <= '0;
      dist_high <= '0;
      bytes_out <= '0;
      wpos      <= '0;
      cons_left <= '0;
      pend      <= 1'b0;
      fwd       <= 1'b0;
      pack_lane <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.tok_load) begin
        token     <= in_byte;
        lit_left  <= sts.b_lit_zero ? 8'd0 : {6'd0, in_byte[1:0]} - 8'd1;
        match_len <= {4'd0, in_byte[7:4]};
      end
      if (cmd.litext_load) begin
        lit_left  <= sts.b_zero ? 8'd0 : in_byte - 8'd1;
        match_len <= {4'd0, token[7:4]};
      end
      if (cmd.matext_load) begin
        match_len <= in_byte;
      end
      if (cmd.dlow_load) begin
        dist_low <= in_byte;
        if (!sts.tok_dist_ext) begin
          dist_high <= {6'd0, token[3:2]};
        end
      end
      if (cmd.dhigh_load) begin
        dist_high <= in_byte;
      end
      if (cmd.lit_emit) begin
        lit_left <= lit_left - 8'd1;
      end
      if (wr_en) begin
        wpos      <= wpos_inc;
        bytes_out <= bytes_out_inc;
      end
      if (cmd.setup) begin
        cons_left <= LEN_W'(match_len) + LEN_W'(MLEN_BIAS);
        pend      <= 1'b0;
        fwd       <= 1'b0;
        pack_lane <= '0;
      end
      if (cmd.copy_en) begin
        pend <= issue || (pend && !consume);
      end
      if (issue) begin
        // dist of one reads the byte being written this cycle
        fwd <= wr_en && (rpos == wpos);
      end
      if (consume) begin
        cons_left <= cons_left - LEN_W'(1);
        pack_lane <= completes ? '0 : pack_lane + 1'b1;
      end
      if (cmd.lit_emit || (consume && completes)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      bad       <= bad_calc;
      rpos      <= rpos_calc;
      pack_data <= '0;
    end
    if (issue) begin
      rpos     <= rpos_inc;
      fwd_byte <= wr_data;
    end
    if (consume) begin
      pack_data <= completes ? '0 : (pack_data | lane_bits);
    end
    if (cmd.lit_emit) begin
      out_data      <= DATA_W'(in_byte);
      out_count     <= CNT_W'(1);
      run_last      <= 1'b1;
      bad_distance  <= 1'b0;
      limit_reached <= limit_next;
    end else if (consume && completes) begin
      out_data      <= pack_data | lane_bits;
      out_count     <= CNT_W'(pack_lane) + CNT_W'(1);
      run_last      <= copy_last;
      bad_distance  <= bad;
      limit_reached <= limit_next;
    end
  end

endmodule

### design/lz_token_decompressor_unit.sv
// LZ token decompressor, top level: configuration port, parser FSM, datapath.
// Depends on lztd_pkg, lztd_in_if, lztd_out_if, lztd_ctrl, lztd_dp and the
// assertion macro header.
//
// token_ch takes one compressed byte per transfer; result_ch returns packed
// output bytes (first byte in bits 7:0, up to OUT_LANES per transfer) with
// out_count, run_last, bad_distance and limit_reached.
// Header bytes (token, count extensions, distance bytes) are taken whenever
// token_ch is valid. A literal byte is accepted once the output register is
// free; its result is valid the next cycle.
// A match passes through a setup state, then the copy state reads each copied
// byte through the history RAM read port, issuing the next read as the current
// byte retires, and returns to the token phase; match length is 3..257.
// Matches of distance one use a write-to-read bypass, so they need no extra wait.
// When result_ch stalls, the literal phase holds token_ch ready low; the copy
// engine freezes with its one read in flight once a packed word is complete.
// Once the output count reaches out_size, token bytes are accepted and
// dropped. out_size is at APB address 0.
// Reset clears the parser and counters; the window needs no clearing since a
// byte read from an unwritten entry is flagged as a bad distance and zeroed.
`include "lz_token_decompressor_unit_macros.svh"

module lz_token_decompressor_unit #(
  parameter int WINDOW_DEPTH = lztd_pkg::WINDOW_DEPTH_DEF,
  parameter int OUT_LANES    = lztd_pkg::OUT_LANES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lztd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  lztd_in_if.sink                         token_ch,
  lztd_out_if.source                      result_ch
);
  import lztd_pkg::*;

  logic [31:0] out_size;
  logic        cfg_wr;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_OUT_SIZE) ? out_size : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_size <= '0;
    end else if (cfg_wr && (paddr[2] == REG_OUT_SIZE)) begin
      out_size <= pwdata;
    end
  end

  lztd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (token_ch.valid),
    .in_ready (token_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lztd_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .OUT_LANES    (OUT_LANES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_byte       (token_ch.in_byte),
    .out_size      (out_size),
    .out_ready     (result_ch.ready),
    .out_valid     (result_ch.valid),
    .out_data      (result_ch.out_data),
    .out_count     (result_ch.out_count),
    .run_last      (result_ch.run_last),
    .bad_distance  (result_ch.bad_distance),
    .limit_reached (result_ch.limit_reached)
  );

  `LZTD_ASSERT_IMPL(a_lit_out_free, clk, rst, cmd.lit_emit, sts.out_free, "literal into busy output")
  `LZTD_ASSERT_IMPL(a_copy_no_input, clk, rst, cmd.copy_en, !token_ch.ready, "input taken during copy")
  `LZTD_ASSERT_NEXT(a_setup_then_copy, clk, rst, cmd.setup, cmd.copy_en, "copy did not follow setup")
  `LZTD_ASSERT_IMPL(a_partial_is_last, clk, rst, result_ch.valid && !result_ch.run_last, result_ch.out_count == CNT_W'(OUT_LANES), "short result not last")

endmodule
